[rtl/core/ultrasonic_echo_ranger_defines.svh]
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Property shorthands shared by the checker of the ranger.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, clocked on clock and disabled in reset.
`define UER_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock and disabled in reset.
`define UER_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/uer_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Types, register codes and conversion constants shared by the ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

   localparam int COUNT_BITS = 20;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam int TIMEOUT_W = 20;
   localparam int TRIG_W    = 8;
   localparam int SCALE_W   = 16;
   localparam int OFFSET_W  = 13;
   localparam int DIST_W    = 14;
   localparam int WIDTH_W   = 15;

   localparam logic [DIST_W-1:0] DIST_MAX = 14'd15984;

   // Distance = round(t * 343 * scale / 20480000); 20480000 = 2^15 * 625.
   localparam int SPEED_W = 9;
   localparam logic [SPEED_W-1:0] SPEED_NUM = 9'd343;
   localparam int PROD1_W = COUNT_BITS + SPEED_W;
   localparam int PROD2_W = PROD1_W + SCALE_W;
   localparam logic [PROD2_W-1:0] ROUND_BIAS = PROD2_W'(10240000);
   localparam int POW2_SHIFT  = 15;
   localparam int QUOT_IN_W   = PROD2_W - POW2_SHIFT;
   localparam int DIV_ODD     = 625;
   localparam int RECIP_SHIFT = QUOT_IN_W + 10;
   localparam int RECIP_W     = RECIP_SHIFT - 9;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
   localparam int PROD3_W = QUOT_IN_W + RECIP_W;
   localparam int QUOT_W  = PROD3_W - RECIP_SHIFT;
   localparam int SUM_W   = QUOT_W + 2;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd30000;
   localparam logic [TRIG_W-1:0]    TRIG_RESET    = 8'd10;
   localparam logic [SCALE_W-1:0]   SCALE_RESET   = 16'd16384;
   localparam logic [DIST_W-1:0]    WARN_RESET    = 14'd320;
   localparam logic [DIST_W-1:0]    DETECT_RESET  = 14'd480;

   typedef enum logic [2:0] {
      REG_TIMEOUT,
      REG_TRIG_LEN,
      REG_CAL_SCALE,
      REG_CAL_OFFSET,
      REG_WARN_DIST,
      REG_DETECT_THR
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_WAIT,
      PH_MEAS
   } phase_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCALE,
      CTL_RECIP,
      CTL_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic start_req;
      logic echo;
   } req_type;

   typedef struct packed {
      logic               trigger;
      logic               done_res;
      logic [DIST_W-1:0]  distance_sixteenths;
      logic               timed_out;
      logic               obj_found;
      logic [WIDTH_W-1:0] object_width;
      logic               warning_active;
      logic               avoid_event;
   } rsp_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0]       timeout_us;
      logic [TRIG_W-1:0]          trigger_length_us;
      logic [SCALE_W-1:0]         cal_scale;
      logic signed [OFFSET_W-1:0] cal_offset;
      logic [DIST_W-1:0]          warn_distance;
      logic [DIST_W-1:0]          detect_threshold;
   } cfg_type;

   typedef struct packed {
      logic step;
      logic load_direct;
      logic load_conv;
   } cmd_type;

   typedef struct packed {
      logic needs_conv;
   } status_type;

endpackage

[rtl/core/uer_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger register file
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module uer_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [uer_pkg::ADDR_W-1:0]    paddr,
   input  logic [uer_pkg::DATA_W-1:0]    pwdata,
   output logic [uer_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   output uer_pkg::cfg_type              cfg
);

   uer_pkg::cfg_type       cfg_ff;
   uer_pkg::cfg_type       cfg_in;
   uer_pkg::reg_index_type reg_idx;
   logic                   wr_en;

   assign pready  = 1'b1;
   assign reg_idx = uer_pkg::reg_index_type'(paddr[uer_pkg::ADDR_W-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            uer_pkg::REG_TIMEOUT:    cfg_in.timeout_us = pwdata[uer_pkg::TIMEOUT_W-1:0];
            uer_pkg::REG_TRIG_LEN:   cfg_in.trigger_length_us = pwdata[uer_pkg::TRIG_W-1:0];
            uer_pkg::REG_CAL_SCALE:  cfg_in.cal_scale = pwdata[uer_pkg::SCALE_W-1:0];
            uer_pkg::REG_CAL_OFFSET: cfg_in.cal_offset = $signed(pwdata[uer_pkg::OFFSET_W-1:0]);
            uer_pkg::REG_WARN_DIST:  cfg_in.warn_distance = pwdata[uer_pkg::DIST_W-1:0];
            uer_pkg::REG_DETECT_THR: cfg_in.detect_threshold = pwdata[uer_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         uer_pkg::REG_TIMEOUT:    prdata = uer_pkg::DATA_W'(cfg_ff.timeout_us);
         uer_pkg::REG_TRIG_LEN:   prdata = uer_pkg::DATA_W'(cfg_ff.trigger_length_us);
         uer_pkg::REG_CAL_SCALE:  prdata = uer_pkg::DATA_W'(cfg_ff.cal_scale);
         uer_pkg::REG_CAL_OFFSET: prdata = uer_pkg::DATA_W'($unsigned(cfg_ff.cal_offset));
         uer_pkg::REG_WARN_DIST:  prdata = uer_pkg::DATA_W'(cfg_ff.warn_distance);
         uer_pkg::REG_DETECT_THR: prdata = uer_pkg::DATA_W'(cfg_ff.detect_threshold);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_us        <= uer_pkg::TIMEOUT_RESET;
         cfg_ff.trigger_length_us <= uer_pkg::TRIG_RESET;
         cfg_ff.cal_scale         <= uer_pkg::SCALE_RESET;
         cfg_ff.cal_offset        <= '0;
         cfg_ff.warn_distance     <= uer_pkg::WARN_RESET;
         cfg_ff.detect_threshold  <= uer_pkg::DETECT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/uer_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger controller
// Handshake control and sequencing of the distance conversion.
// ----------------------------------------------------------------------------
module uer_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  uer_pkg::status_type status,
   output uer_pkg::cmd_type    cmd
);

   uer_pkg::ctl_state_type state_ff;
   uer_pkg::ctl_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   out_free;
   logic                   accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == uer_pkg::CTL_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         uer_pkg::CTL_IDLE: begin
            if (accept) begin
               cmd.step = 1'b1;
               if (status.needs_conv) begin
                  state_in = uer_pkg::CTL_SCALE;
               end else begin
                  cmd.load_direct = 1'b1;
               end
            end
         end
         uer_pkg::CTL_SCALE: begin
            state_in = uer_pkg::CTL_RECIP;
         end
         uer_pkg::CTL_RECIP: begin
            state_in = uer_pkg::CTL_FINISH;
         end
         uer_pkg::CTL_FINISH: begin
            cmd.load_conv = 1'b1;
            state_in      = uer_pkg::CTL_IDLE;
         end
         default: begin
            state_in = uer_pkg::CTL_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_direct || cmd.load_conv || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uer_pkg::CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/uer_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger datapath
// Tick counters, echo timing, distance conversion pipeline and result register.
// ----------------------------------------------------------------------------
module uer_datapath (
   input  logic                clock,
   input  logic                reset,
   input  uer_pkg::cmd_type    cmd,
   input  uer_pkg::req_type    req,
   input  uer_pkg::cfg_type    cfg,
   output uer_pkg::status_type status,
   output uer_pkg::rsp_type    rsp
);

   uer_pkg::phase_type                   phase_ff;
   uer_pkg::phase_type                   phase_in;
   logic [uer_pkg::COUNT_BITS-1:0]       tick_ff;
   logic [uer_pkg::COUNT_BITS-1:0]       tick_in;
   logic [uer_pkg::COUNT_BITS-1:0]       echo_time_ff;
   logic [uer_pkg::COUNT_BITS-1:0]       echo_time_in;
   logic                                 warn_ff;
   logic                                 warn_in;
   logic [uer_pkg::PROD1_W-1:0]          prod1_ff;
   logic [uer_pkg::PROD2_W-1:0]          prod2_ff;
   logic [uer_pkg::PROD3_W-1:0]          prod3_ff;
   uer_pkg::rsp_type                     rsp_ff;
   uer_pkg::rsp_type                     rsp_in;

   logic [uer_pkg::TRIG_W-1:0]           tlen;
   logic [uer_pkg::COUNT_BITS-1:0]       tick_inc;
   logic [uer_pkg::COUNT_BITS-1:0]       echo_inc;
   logic                                 trig;
   logic                                 tdone;
   logic [uer_pkg::PROD2_W-1:0]          biased;
   logic [uer_pkg::QUOT_IN_W-1:0]        quot_in;
   logic [uer_pkg::QUOT_W-1:0]           quot;
   logic signed [uer_pkg::SUM_W-1:0]     dist_sum;
   logic [uer_pkg::DIST_W-1:0]           conv_dist;
   logic [uer_pkg::DIST_W-1:0]           fin_dist;
   logic                                 fin_done;
   logic                                 near;

   assign tlen     = (cfg.trigger_length_us == '0) ? uer_pkg::TRIG_W'(1) : cfg.trigger_length_us;
   assign tick_inc = (tick_ff == uer_pkg::COUNT_MAX) ? tick_ff : tick_ff + 1'b1;
   assign echo_inc = (echo_time_ff == uer_pkg::COUNT_MAX) ? echo_time_ff : echo_time_ff + 1'b1;

   assign status.needs_conv = (phase_ff == uer_pkg::PH_MEAS) && !req.echo;

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      echo_time_in = echo_time_ff;
      trig         = 1'b0;
      tdone        = 1'b0;
      unique case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (req.start_req) begin
               trig         = 1'b1;
               tick_in      = uer_pkg::COUNT_BITS'(1);
               echo_time_in = '0;
               phase_in     = (tlen == uer_pkg::TRIG_W'(1)) ? uer_pkg::PH_WAIT : uer_pkg::PH_TRIG;
            end
         end
         uer_pkg::PH_TRIG: begin
            trig    = 1'b1;
            tick_in = tick_inc;
            if (tick_inc >= uer_pkg::COUNT_BITS'(tlen)) begin
               phase_in = uer_pkg::PH_WAIT;
            end
         end
         uer_pkg::PH_WAIT, uer_pkg::PH_MEAS: begin
            tick_in = tick_inc;
            if (phase_ff == uer_pkg::PH_MEAS && !req.echo) begin
               phase_in = uer_pkg::PH_IDLE;
            end else begin
               if (req.echo) begin
                  echo_time_in = (phase_ff == uer_pkg::PH_WAIT) ?
                                 uer_pkg::COUNT_BITS'(1) : echo_inc;
                  phase_in     = uer_pkg::PH_MEAS;
               end
               if (tick_inc >= uer_pkg::COUNT_BITS'(cfg.timeout_us) ||
                   tick_inc == uer_pkg::COUNT_MAX) begin
                  tdone    = 1'b1;
                  phase_in = uer_pkg::PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = uer_pkg::PH_IDLE;
         end
      endcase
   end

   // The biased product stays below 2^PROD2_W for every echo time and scale.
   assign biased   = prod2_ff + uer_pkg::ROUND_BIAS;
   assign quot_in  = biased[uer_pkg::PROD2_W-1:uer_pkg::POW2_SHIFT];
   assign quot     = prod3_ff[uer_pkg::RECIP_SHIFT +: uer_pkg::QUOT_W];
   assign dist_sum = $signed({2'b00, quot}) + uer_pkg::SUM_W'(cfg.cal_offset);

   always_comb begin
      if (dist_sum < 0) begin
         conv_dist = '0;
      end else if (dist_sum > $signed(uer_pkg::SUM_W'(uer_pkg::DIST_MAX))) begin
         conv_dist = uer_pkg::DIST_MAX;
      end else begin
         conv_dist = dist_sum[uer_pkg::DIST_W-1:0];
      end
   end

   always_comb begin
      fin_done = cmd.load_conv || tdone;
      if (cmd.load_conv) begin
         fin_dist = conv_dist;
      end else if (tdone) begin
         fin_dist = uer_pkg::DIST_MAX;
      end else begin
         fin_dist = '0;
      end
      near = fin_done && (fin_dist <= cfg.warn_distance);
      warn_in = fin_done ? near : warn_ff;

      rsp_in.trigger             = cmd.load_conv ? 1'b0 : trig;
      rsp_in.done_res            = fin_done;
      rsp_in.distance_sixteenths = fin_dist;
      rsp_in.timed_out           = cmd.load_conv ? 1'b0 : tdone;
      rsp_in.obj_found           = fin_done && (fin_dist < cfg.detect_threshold) &&
                                   (fin_dist > uer_pkg::DIST_W'(1));
      rsp_in.object_width        = rsp_in.obj_found ?
                                   {fin_dist, 1'b0} : '0;
      rsp_in.warning_active      = warn_in;
      rsp_in.avoid_event         = near && !warn_ff;
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= uer_pkg::PH_IDLE;
         tick_ff      <= '0;
         echo_time_ff <= '0;
         warn_ff      <= 1'b0;
      end else begin
         if (cmd.step) begin
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            echo_time_ff <= echo_time_in;
         end
         if (cmd.load_direct || cmd.load_conv) begin
            warn_ff <= warn_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= uer_pkg::PROD1_W'(echo_time_ff) * uer_pkg::PROD1_W'(uer_pkg::SPEED_NUM);
      prod2_ff <= uer_pkg::PROD2_W'(prod1_ff) * uer_pkg::PROD2_W'(cfg.cal_scale);
      prod3_ff <= uer_pkg::PROD3_W'(quot_in) * uer_pkg::PROD3_W'(uer_pkg::RECIP);
      if (cmd.load_direct || cmd.load_conv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[rtl/core/ultrasonic_echo_ranger.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger and echo timing for a pulse-echo range sensor, one tick per item,
// with calibrated distance, object report and near-obstacle warning.
// ----------------------------------------------------------------------------
//  Channel  Dir     Handshake              Payload
//  req      in      req_valid / req_stall  uer_pkg::req_type (start_req, echo)
//  rsp      out     rsp_valid / rsp_stall  uer_pkg::rsp_type (one per item)
//  config   in/out  psel / penable / pready  six registers at 4*i, 32-bit data
//
// An ordinary tick is loaded straight into the output register, back to back
// while no result is stalled. On a tick where the echo falls, the conversion
// runs three registered multiplies: by 343, by scale, by the 1/625 reciprocal.
// Reset is synchronous and takes effect at once; there is no clearing pass.
// A stalled result holds and blocks new items until it is taken.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  uer_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output uer_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [uer_pkg::ADDR_W-1:0]    paddr,
   input  logic [uer_pkg::DATA_W-1:0]    pwdata,
   output logic [uer_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   uer_pkg::cfg_type    cfg;
   uer_pkg::cmd_type    cmd;
   uer_pkg::status_type status;

   uer_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   uer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   uer_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .req    (req_data),
      .cfg    (cfg),
      .status (status),
      .rsp    (rsp_data)
   );

endmodule

[rtl/core/uer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger checker
// Port-level checks on the result channel of the ranger.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_defines.svh"

module uer_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input uer_pkg::rsp_type rsp_data
);

   `UER_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled item changed")
   `UER_ASSERT_IMP(a_idle_zero, rsp_valid && !rsp_data.done_res, rsp_data.distance_sixteenths == 0 && rsp_data.object_width == 0 && !rsp_data.timed_out && !rsp_data.avoid_event, "idle item carries a measurement")
   `UER_ASSERT_IMP(a_timeout_dist, rsp_valid && rsp_data.timed_out, rsp_data.done_res && rsp_data.distance_sixteenths == uer_pkg::DIST_MAX, "timeout without full-range distance")
   `UER_ASSERT_IMP(a_width, rsp_valid && rsp_data.obj_found, rsp_data.object_width == (15'(rsp_data.distance_sixteenths) << 1), "object width is not twice the distance")
   `UER_ASSERT_IMP(a_avoid_warn, rsp_valid && rsp_data.avoid_event, rsp_data.warning_active, "avoid event without warning")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);
